FILE: hw/rtl/rre_pkg.sv
package rre_pkg;

  typedef enum logic {
    OP_RCP = 1'b0,
    OP_RSQ = 1'b1
  } op_e;

  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_MASK = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEF_NAN   = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SGL_MAX   = 64'h47EF_FFFF_E000_0000;

  localparam logic [10:0] EXP_MAX      = 11'h7FF;
  localparam logic [10:0] RCP_EXP_LO   = 11'd895;
  localparam logic [10:0] RCP_EXP_HI   = 11'd1149;
  localparam logic [10:0] RCP_EXP_BIAS = 11'h7FD;
  localparam logic [11:0] RSQ_EXP_BIAS = 12'hBFC;

  localparam logic [25:0] RSQ_BASE [32] = '{
    26'h3ffa000, 26'h3c29000, 26'h38aa000, 26'h3572000,
    26'h3279000, 26'h2fb7000, 26'h2d26000, 26'h2ac0000,
    26'h2881000, 26'h2665000, 26'h2468000, 26'h2287000,
    26'h20c1000, 26'h1f12000, 26'h1d79000, 26'h1bf4000,
    26'h1a7e800, 26'h17cb800, 26'h1552800, 26'h130c000,
    26'h10f2000, 26'h0eff000, 26'h0d2e000, 26'h0b7c000,
    26'h09e5000, 26'h0867000, 26'h06ff000, 26'h05ab800,
    26'h046a000, 26'h0339800, 26'h0218800, 26'h0105800
  };

  localparam logic [10:0] RSQ_SLOPE [32] = '{
    11'h7a4, 11'h700, 11'h670, 11'h5f2, 11'h584, 11'h524, 11'h4cc, 11'h47e,
    11'h43a, 11'h3fa, 11'h3c2, 11'h38e, 11'h35e, 11'h332, 11'h30a, 11'h2e6,
    11'h568, 11'h4f3, 11'h48d, 11'h435, 11'h3e7, 11'h3a2, 11'h365, 11'h32e,
    11'h2fc, 11'h2d0, 11'h2a8, 11'h283, 11'h261, 11'h243, 11'h226, 11'h20b
  };

  localparam logic [25:0] RCP_BASE [32] = '{
    26'h07ff800, 26'h0783800, 26'h070ea00, 26'h06a0800,
    26'h0638800, 26'h05d6200, 26'h0579000, 26'h0520800,
    26'h04cc800, 26'h047ca00, 26'h0430800, 26'h03e8000,
    26'h03a2c00, 26'h0360800, 26'h0321400, 26'h02e4a00,
    26'h02aa800, 26'h0272c00, 26'h023d600, 26'h0209e00,
    26'h01d8800, 26'h01a9000, 26'h017ae00, 26'h014f800,
    26'h0124400, 26'h00fbe00, 26'h00d3800, 26'h00ade00,
    26'h0088400, 26'h0065000, 26'h0041c00, 26'h0020c00
  };

  localparam logic [10:0] RCP_SLOPE [32] = '{
    11'h3e1, 11'h3a7, 11'h371, 11'h340, 11'h313, 11'h2ea, 11'h2c4, 11'h2a0,
    11'h27f, 11'h261, 11'h245, 11'h22a, 11'h212, 11'h1fb, 11'h1e5, 11'h1d1,
    11'h1be, 11'h1ac, 11'h19b, 11'h18b, 11'h17c, 11'h16e, 11'h15b, 11'h15b,
    11'h143, 11'h143, 11'h12d, 11'h12d, 11'h11a, 11'h11a, 11'h108, 11'h106
  };

  // decode -> lookup
  typedef struct packed {
    op_e         op;
    logic        sign;
    logic        special;
    logic [63:0] spec_res;
    logic [10:0] exp;
    logic [51:0] frac;
    logic [5:0]  lzc;
  } dec_t;

  // lookup -> interpolate
  typedef struct packed {
    op_e         op;
    logic        sign;
    logic        special;
    logic [63:0] spec_res;
    logic [10:0] new_exp;
    logic [25:0] base;
    logic [10:0] slope;
    logic [10:0] pos;
  } lkp_t;

endpackage

FILE: hw/rtl/rre_decode.sv
module rre_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rre_pkg::op_e  opcode_i,
  input  logic [63:0]   operand_i,
  output logic          valid_o,
  output rre_pkg::dec_t stage_o
);
  import rre_pkg::*;

  logic        sign;
  logic [10:0] exp;
  logic [51:0] frac;
  logic        is_zero;
  logic        is_max;
  logic        special;
  logic [63:0] spec_res;
  logic [5:0]  lzc;
  logic        found;
  logic        valid_q;
  dec_t        stage_d, stage_q;

  assign sign    = operand_i[63];
  assign exp     = operand_i[62:52];
  assign frac    = operand_i[51:0];
  assign is_zero = (exp == '0) && (frac == '0);
  assign is_max  = (exp == EXP_MAX);

  // resolve special operands before any table work
  always_comb begin
    special  = 1'b1;
    spec_res = '0;
    if (opcode_i == OP_RCP) begin
      priority if (is_zero) begin
        spec_res = {sign, 63'b0} | INF_BITS;
      end else if (is_max) begin
        spec_res = (frac == '0) ? {sign, 63'b0} : (operand_i | QNAN_MASK);
      end else if (exp < RCP_EXP_LO) begin
        spec_res = {sign, 63'b0} | SGL_MAX;
      end else if (exp >= RCP_EXP_HI) begin
        spec_res = {sign, 63'b0};
      end else begin
        special = 1'b0;
      end
    end else begin
      priority if (is_zero) begin
        spec_res = {sign, 63'b0} | INF_BITS;
      end else if (is_max) begin
        if (frac == '0) begin
          spec_res = sign ? DEF_NAN : '0;
        end else begin
          spec_res = operand_i | QNAN_MASK;
        end
      end else if (sign) begin
        spec_res = DEF_NAN;
      end else begin
        special = 1'b0;
      end
    end
  end

  // leading zeros of the fraction, used to normalize denormals
  always_comb begin
    lzc   = '0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && frac[i]) begin
        lzc   = 6'(51 - i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    stage_d.op       = opcode_i;
    stage_d.sign     = sign;
    stage_d.special  = special;
    stage_d.spec_res = spec_res;
    stage_d.exp      = exp;
    stage_d.frac     = frac;
    stage_d.lzc      = lzc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/rre_lookup.sv
module rre_lookup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rre_pkg::dec_t stage_i,
  output logic          valid_o,
  output rre_pkg::lkp_t stage_o
);
  import rre_pkg::*;

  logic        denorm;
  logic [5:0]  shift;
  logic [51:0] norm_frac;
  logic [14:0] f;
  logic [11:0] rsq_t;
  logic [4:0]  idx;
  logic        valid_q;
  lkp_t        stage_d, stage_q;

  assign denorm    = (stage_i.exp == '0);
  assign shift     = stage_i.lzc + 6'd1;
  assign norm_frac = stage_i.frac << shift;
  assign f         = denorm ? norm_frac[51:37] : stage_i.frac[51:37];

  // 0xBFC minus the effective exponent; its low bit carries the exponent parity
  assign rsq_t = denorm ? (RSQ_EXP_BIAS - 12'd1 + {6'b0, shift})
                        : (RSQ_EXP_BIAS - {1'b0, stage_i.exp});

  always_comb begin
    stage_d.op       = stage_i.op;
    stage_d.sign     = stage_i.sign;
    stage_d.special  = stage_i.special;
    stage_d.spec_res = stage_i.spec_res;
    unique case (stage_i.op)
      OP_RSQ: begin
        idx             = {~rsq_t[0], f[14:11]};
        stage_d.new_exp = rsq_t[11:1];
        stage_d.base    = RSQ_BASE[idx];
        stage_d.slope   = RSQ_SLOPE[idx];
        stage_d.pos     = f[10:0];
      end
      default: begin
        idx             = f[14:10];
        stage_d.new_exp = RCP_EXP_BIAS - stage_i.exp;
        stage_d.base    = RCP_BASE[idx];
        stage_d.slope   = RCP_SLOPE[idx];
        stage_d.pos     = {1'b0, f[9:0]};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/rre_interp.sv
module rre_interp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rre_pkg::lkp_t stage_i,
  output logic          valid_o,
  output logic [63:0]   result_o
);
  import rre_pkg::*;

  // multiply stage
  logic        mul_valid_q;
  op_e         mul_op_q;
  logic        mul_sign_q;
  logic        mul_special_q;
  logic [63:0] mul_spec_q;
  logic [10:0] mul_exp_q;
  logic [25:0] mul_base_q;
  logic [21:0] prod_d, prod_q;

  // assemble stage
  logic [22:0] rcp_adj;
  logic [21:0] sub;
  logic [26:0] diff;
  logic        borrow;
  logic [25:0] m;
  logic [63:0] result_d, result_q;
  logic        out_valid_q;

  assign prod_d = stage_i.slope * stage_i.pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= valid_i;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mul_op_q      <= stage_i.op;
      mul_sign_q    <= stage_i.sign;
      mul_special_q <= stage_i.special;
      mul_spec_q    <= stage_i.spec_res;
      mul_exp_q     <= stage_i.new_exp;
      mul_base_q    <= stage_i.base;
      prod_q        <= prod_d;
    end
  end

  // reciprocal rounds half the product up
  assign rcp_adj = ({1'b0, prod_q} + 23'd1) >> 1;
  assign sub     = (mul_op_q == OP_RSQ) ? prod_q : rcp_adj[21:0];
  assign diff    = {1'b0, mul_base_q} - {5'b0, sub};
  assign borrow  = diff[26];
  assign m       = diff[25:0];

  always_comb begin
    if (mul_special_q) begin
      result_d = mul_spec_q;
    end else if (mul_op_q == OP_RSQ) begin
      // a negative mantissa sign-extends over the sign and exponent bits
      result_d = {{12{borrow}} | {1'b0, mul_exp_q}, m, 26'b0};
    end else begin
      result_d = {mul_sign_q, mul_exp_q, m[22:0], 29'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = result_q;

endmodule

FILE: hw/rtl/reciprocal_and_rsqrt_estimate.sv
// valid_o is the start transfer registered through the decode, lookup, multiply and assemble valid bits.
// Throughput: one operation per cycle; busy stays low, so start is taken every cycle.
// Stages: decode and leading-zero count, normalize and table lookup, multiply, assemble.
// Each result shows for exactly one cycle with valid_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers keep no reset.
module reciprocal_and_rsqrt_estimate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [63:0] operand_i,
  output logic        valid_o,
  output logic [63:0] result_o
);
  import rre_pkg::*;

  logic accept;
  op_e  opcode;
  logic dec_valid;
  dec_t dec_stage;
  logic lkp_valid;
  lkp_t lkp_stage;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign opcode = op_e'(opcode_i);

  rre_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .opcode_i  (opcode),
    .operand_i (operand_i),
    .valid_o   (dec_valid),
    .stage_o   (dec_stage)
  );

  rre_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .stage_i (dec_stage),
    .valid_o (lkp_valid),
    .stage_o (lkp_stage)
  );

  rre_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (lkp_valid),
    .stage_i  (lkp_stage),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 4))
    else $error("result strobe without a start four cycles earlier");

  // only an all-ones exponent field may carry a set sign here
  a_rsq_positive_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(opcode_i, 4) && !$past(operand_i[63], 4)
    |-> !result_o[63] || (result_o[62:52] == EXP_MAX))
    else $error("rsqrt estimate of a positive operand has sign set");

  a_rcp_exponent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !$past(opcode_i, 4)
      && ($past(operand_i[62:52], 4) >= RCP_EXP_LO)
      && ($past(operand_i[62:52], 4) < RCP_EXP_HI)
    |-> result_o[62:52] == RCP_EXP_BIAS - $past(operand_i[62:52], 4))
    else $error("reciprocal estimate exponent mismatch");

endmodule
